// ===== hdl/csd_pkg.sv =====
// Shared types, constants and helpers for the COBS stream decoder.
package csd_pkg;

  localparam logic [7:0] DELIM       = 8'h00;
  localparam logic [7:0] AWAIT       = 8'hFF;
  localparam logic [7:0] MAX_PAYLOAD = 8'd253;
  localparam logic [7:0] SIZE_RESET  = 8'd253;

  typedef struct packed {
    logic [7:0] code_left;
    logic [7:0] bytes_decoded;
  } csd_state_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic       frame_done;
    logic [7:0] frame_length;
    logic       overflow;
  } csd_result_t;

  // Clamps the configured size into the supported range of payload lengths.
  function automatic logic [7:0] limit_of(input logic [7:0] size);
    logic [7:0] lim;
    if (size == 8'd0) begin
      lim = 8'd1;
    end else if (size > MAX_PAYLOAD) begin
      lim = MAX_PAYLOAD;
    end else begin
      lim = size;
    end
    return lim;
  endfunction

endpackage

// ===== hdl/csd_decode.sv =====
// Next-state and result logic for one received byte.
module csd_decode (
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          buffer_size,
  input  csd_pkg::csd_state_t state,
  output csd_pkg::csd_state_t state_next,
  output csd_pkg::csd_result_t result
);
  import csd_pkg::*;

  logic [7:0] val;
  logic [7:0] code_next;
  logic [7:0] limit;

  assign limit = limit_of(buffer_size);

  always_comb begin
    state_next = state;
    result     = '0;
    val        = 8'd0;
    code_next  = 8'd0;

    if (rx_byte == DELIM) begin
      state_next.code_left     = AWAIT;
      state_next.bytes_decoded = 8'd0;
      if (state.code_left == 8'd0 && state.bytes_decoded != 8'd0) begin
        result.frame_done   = 1'b1;
        result.frame_length = state.bytes_decoded;
      end
    end else if (state.code_left == AWAIT) begin
      // Without a preceding delimiter the byte is ignored.
      if (state.bytes_decoded == 8'd0) begin
        state_next.code_left = rx_byte - 8'd1;
      end
    end else begin
      if (state.code_left == 8'd0) begin
        // A code byte stands for the zero that ended the previous group.
        code_next = rx_byte - 8'd1;
        val       = 8'd0;
      end else begin
        code_next = state.code_left - 8'd1;
        val       = rx_byte;
      end
      if (state.bytes_decoded < limit) begin
        state_next.code_left     = code_next;
        state_next.bytes_decoded = state.bytes_decoded + 8'd1;
        result.byte_valid        = 1'b1;
        result.byte_value        = val;
        result.byte_index        = state.bytes_decoded;
      end else begin
        state_next.code_left = AWAIT;
        result.overflow      = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/csd_out_reg.sv =====
// Result register with valid/stall handshake toward the receiver.
module csd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  csd_pkg::csd_result_t result_in,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 full_stalled,
  output csd_pkg::csd_result_t result_out
);
  import csd_pkg::*;

  assign full_stalled = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== hdl/cobs_stream_decoder_top.sv =====
// Top level of the COBS stream decoder.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+--------------------------------------
//   input   | in        | in_valid / in_stall  | rx_byte
//   output  | out       | out_valid / out_stall| byte_valid, byte_value, byte_index,
//           |           |                      | frame_done, frame_length, overflow
//   config  | in        | cfg_wr_en            | cfg_wr_data (buffer_size)
//
// Every accepted byte gives one item, which is registered and shown on the output in the cycle after acceptance.
// One byte is taken per cycle while in_stall is low; the decode state is updated at the accepting edge.
// in_stall rises only while reset is held or a result waits under out_stall.
// Reset is synchronous: the decoder awaits a start delimiter, buffer_size is 253.
module cobs_stream_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       byte_valid,
  output logic [7:0] byte_value,
  output logic [7:0] byte_index,
  output logic       frame_done,
  output logic [7:0] frame_length,
  output logic       overflow,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import csd_pkg::*;

  logic        [7:0] buffer_size;
  csd_state_t        state;
  csd_state_t        state_next;
  csd_result_t       result_next;
  csd_result_t       result;
  logic              accept;
  logic              full_stalled;

  assign in_stall = rst || full_stalled;
  assign accept   = in_valid && !in_stall;

  csd_decode u_decode (
    .rx_byte     (rx_byte),
    .buffer_size (buffer_size),
    .state       (state),
    .state_next  (state_next),
    .result      (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.code_left     <= AWAIT;
      state.bytes_decoded <= AWAIT;
      buffer_size         <= SIZE_RESET;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (cfg_wr_en) begin
        buffer_size <= cfg_wr_data;
      end
    end
  end

  csd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .result_in    (result_next),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .full_stalled (full_stalled),
    .result_out   (result)
  );

  assign byte_valid   = result.byte_valid;
  assign byte_value   = result.byte_value;
  assign byte_index   = result.byte_index;
  assign frame_done   = result.frame_done;
  assign frame_length = result.frame_length;
  assign overflow     = result.overflow;

endmodule

// ===== hdl/csd_checker.sv =====
// Port-level checks for the COBS stream decoder, bound to the top level.
module csd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       byte_valid,
  input logic [7:0] byte_value,
  input logic [7:0] byte_index,
  input logic       frame_done,
  input logic [7:0] frame_length,
  input logic       overflow
);

  // A result that is held back must keep its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_value) && $stable(byte_index)
      && $stable(frame_length) && $stable(byte_valid) && $stable(frame_done)
      && $stable(overflow))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Each accepted byte shows up as an item on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted byte gave no item");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({byte_valid, frame_done, overflow}) <= 1)
    else $error("more than one kind of result in one item");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid || (byte_value == 8'd0 && byte_index == 8'd0))
      && (frame_done || frame_length == 8'd0))
    else $error("unused result fields not zero");

endmodule

bind cobs_stream_decoder_top csd_checker u_csd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .byte_valid   (byte_valid),
  .byte_value   (byte_value),
  .byte_index   (byte_index),
  .frame_done   (frame_done),
  .frame_length (frame_length),
  .overflow     (overflow)
);
